### rtl/core/jahd_pkg.sv
// shared constants, codes and controller/datapath types for the joystick block
package jahd_pkg;

  // default and field widths
  localparam int SAMPLE_BITS_DEF = 8;
  localparam int ACC_W           = 15;
  localparam int CNT_W           = 8;
  localparam int POS_W           = 7;
  localparam int DIR_W           = 3;
  localparam int CENTRE_W        = 8;
  localparam int WINDOW_W        = 8;
  localparam int HYST_W          = 7;
  localparam int DZ_W            = 6;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;
  // bits needed to hold the half-scale span of 50
  localparam int SPAN_W          = 6;

  // position scale
  localparam logic [POS_W-1:0]  CENTRE_POS = 7'd50;
  localparam logic [SPAN_W-1:0] MAP_SPAN   = 6'd50;

  // register reset values
  localparam logic [CENTRE_W-1:0] CENTRE_RST = 8'd172;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 8'd50;
  localparam logic [HYST_W-1:0]   HYST_RST   = 7'd4;
  localparam logic [DZ_W-1:0]     DZ_RST     = 6'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE = 2'd0,
    CFG_WINDOW = 2'd1,
    CFG_HYST   = 2'd2,
    CFG_DEAD   = 2'd3
  } cfg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NEUTRAL = 3'd0,
    DIR_UP      = 3'd1,
    DIR_DOWN    = 3'd2,
    DIR_LEFT    = 3'd3,
    DIR_RIGHT   = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    SEL_MAP_Y = 2'd0,
    SEL_MAP_X = 2'd1,
    SEL_AVG_X = 2'd2,
    SEL_AVG_Y = 2'd3
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_Y,
    ST_WAIT_Y,
    ST_START_X,
    ST_WAIT_X,
    ST_CHECK,
    ST_START_AX,
    ST_WAIT_AX,
    ST_START_AY,
    ST_WAIT_AY,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_map_y;
    logic     cap_map_x;
    logic     cap_avg_x;
    logic     cap_avg_y;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic win_hit;
    logic out_full;
  } status_t;

endpackage

### rtl/core/jahd_in_if.sv
// sample channel: valid/ready handshake with one raw sample per axis
interface jahd_in_if #(
  parameter int SAMPLE_BITS = jahd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] y_sample;
  logic [SAMPLE_BITS-1:0] x_sample;

  modport source (output valid, output y_sample, output x_sample, input ready);
  modport sink   (input valid, input y_sample, input x_sample, output ready);
endinterface

### rtl/core/jahd_out_if.sv
// result channel: valid/ready handshake with positions and direction
interface jahd_out_if;
  logic                         valid;
  logic                         ready;
  logic [jahd_pkg::POS_W-1:0]   x_position;
  logic [jahd_pkg::POS_W-1:0]   y_position;
  logic [jahd_pkg::DIR_W-1:0]   direction;

  modport source (output valid, output x_position, output y_position, output direction,
                  input ready);
  modport sink   (input valid, input x_position, input y_position, input direction,
                  output ready);
endinterface

### rtl/core/joystick_average_hysteresis_direction.sv
// joystick position block top level: window average, hysteresis and direction
// Each sample transaction carries one raw reading per axis. Both readings are mapped
// onto 0..100 (centre_level maps to 50, truncating) and summed; once window_length
// samples are in (zero counts as one), a result transaction gives the reported x/y
// positions (updated only when the new average moves by more than hysteresis_step)
// and a direction (0 neutral, 1 up, 2 down, 3 left, 4 right) with a dead band around 50.
// All division runs on one shared radix-2 divider, D = max(SAMPLE_BITS + 6, 15)
// quotient bits, one bit per clock. Each sample takes a y and an x mapping divide;
// the sample that closes a window adds an x and a y averaging divide, then publishes.
// A finished result sits in an output register, so the next sample is taken while it
// waits; a new result is held back only while the previous one is still untaken.
// Configuration writes must go in while the block is idle and take effect at once;
// the block itself does not enforce the idle condition.
module joystick_average_hysteresis_direction #(
  parameter int SAMPLE_BITS = jahd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jahd_in_if.sink                         in_ch,
  jahd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [jahd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jahd_pkg::CFG_DATA_W-1:0] cfg_data
);
  // command and status between sequencer and datapath
  jahd_pkg::cmd_t    cmd;
  jahd_pkg::status_t status;

  // sequencer: sample transaction accepted only in idle
  jahd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath with config registers, divider and result register
  jahd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_y_sample    (in_ch.y_sample),
    .in_x_sample    (in_ch.x_sample),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_x_position (out_ch.x_position),
    .out_y_position (out_ch.y_position),
    .out_direction  (out_ch.direction)
  );
endmodule

### rtl/core/jahd_div.sv
// restoring radix-2 unsigned divider, one quotient bit per cycle
module jahd_div #(
  parameter int DVD_W = jahd_pkg::ACC_W,
  parameter int DVS_W = jahd_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule

### rtl/core/jahd_datapath.sv
// config registers, operand select, divider, accumulators, hysteresis and result register
module jahd_datapath #(
  parameter int SAMPLE_BITS = jahd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [jahd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jahd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]           in_y_sample,
  input  logic [SAMPLE_BITS-1:0]           in_x_sample,
  input  jahd_pkg::cmd_t                   cmd,
  output jahd_pkg::status_t                status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [jahd_pkg::POS_W-1:0]       out_x_position,
  output logic [jahd_pkg::POS_W-1:0]       out_y_position,
  output logic [jahd_pkg::DIR_W-1:0]       out_direction
);
  localparam int DVS_W = SAMPLE_BITS;
  localparam int DVD_W = (SAMPLE_BITS + jahd_pkg::SPAN_W > jahd_pkg::ACC_W) ?
                         SAMPLE_BITS + jahd_pkg::SPAN_W : jahd_pkg::ACC_W;
  localparam int POS_W = jahd_pkg::POS_W;
  localparam int CMP_W = POS_W + 1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  // configuration
  logic [jahd_pkg::CENTRE_W-1:0] centre_r;
  logic [jahd_pkg::WINDOW_W-1:0] window_r;
  logic [jahd_pkg::HYST_W-1:0]   hyst_r;
  logic [jahd_pkg::DZ_W-1:0]     dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r <= jahd_pkg::CENTRE_RST;
      window_r <= jahd_pkg::WINDOW_RST;
      hyst_r   <= jahd_pkg::HYST_RST;
      dead_r   <= jahd_pkg::DZ_RST;
    end else if (cfg_we) begin
      case (jahd_pkg::cfg_idx_t'(cfg_index))
        jahd_pkg::CFG_CENTRE: centre_r <= cfg_data[jahd_pkg::CENTRE_W-1:0];
        jahd_pkg::CFG_WINDOW: window_r <= cfg_data[jahd_pkg::WINDOW_W-1:0];
        jahd_pkg::CFG_HYST:   hyst_r   <= cfg_data[jahd_pkg::HYST_W-1:0];
        jahd_pkg::CFG_DEAD:   dead_r   <= cfg_data[jahd_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // latched samples
  logic [SAMPLE_BITS-1:0] samp_y_r;
  logic [SAMPLE_BITS-1:0] samp_x_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      samp_y_r <= in_y_sample;
      samp_x_r <= in_x_sample;
    end
  end

  // state
  logic [jahd_pkg::ACC_W-1:0] acc_x_r;
  logic [jahd_pkg::ACC_W-1:0] acc_y_r;
  logic [jahd_pkg::CNT_W-1:0] count_r;
  logic [POS_W-1:0]           last_x_r;
  logic [POS_W-1:0]           last_y_r;
  logic [POS_W-1:0]           avg_x_r;
  logic [POS_W-1:0]           avg_y_r;

  // operand select for the shared divider
  logic [SAMPLE_BITS-1:0] centre_ext;
  logic [SAMPLE_BITS-1:0] samp_sel;
  logic [SAMPLE_BITS-1:0] span;
  logic                   upper_sel;
  logic [DVD_W-1:0]       dvd;
  logic [DVS_W-1:0]       dvs;
  logic                   div_done;
  logic [DVD_W-1:0]       quo;

  assign centre_ext = SAMPLE_BITS'(centre_r);
  assign samp_sel   = (cmd.div_sel == jahd_pkg::SEL_MAP_Y) ? samp_y_r : samp_x_r;
  assign upper_sel  = samp_sel >= centre_ext;
  assign span       = SAMPLE_MAX - centre_ext;

  always_comb begin
    case (cmd.div_sel)
      jahd_pkg::SEL_MAP_Y, jahd_pkg::SEL_MAP_X: begin
        if (upper_sel) begin
          dvd = DVD_W'(samp_sel - centre_ext) * DVD_W'(jahd_pkg::MAP_SPAN);
          // centre at full scale: only the centre itself lands here, numerator is zero
          dvs = (span == '0) ? DVS_W'(1) : span;
        end else begin
          dvd = DVD_W'(samp_sel) * DVD_W'(jahd_pkg::MAP_SPAN);
          dvs = centre_ext;
        end
      end
      jahd_pkg::SEL_AVG_X: begin
        dvd = DVD_W'(acc_x_r);
        dvs = DVS_W'(count_r);
      end
      jahd_pkg::SEL_AVG_Y: begin
        dvd = DVD_W'(acc_y_r);
        dvs = DVS_W'(count_r);
      end
      default: begin
        dvd = '0;
        dvs = DVS_W'(1);
      end
    endcase
  end

  jahd_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // mapped value from the quotient, upper half sits above the centre
  logic             upper_y;
  logic             upper_x;
  logic [POS_W-1:0] q_pos;
  logic [POS_W-1:0] map_y;
  logic [POS_W-1:0] map_x;

  assign upper_y = samp_y_r >= centre_ext;
  assign upper_x = samp_x_r >= centre_ext;
  assign q_pos   = quo[POS_W-1:0];
  assign map_y   = upper_y ? jahd_pkg::CENTRE_POS + q_pos : q_pos;
  assign map_x   = upper_x ? jahd_pkg::CENTRE_POS + q_pos : q_pos;

  // hysteresis and direction
  function automatic logic [POS_W-1:0] hyst_pick(
    input logic [POS_W-1:0]            prev,
    input logic [POS_W-1:0]            avg,
    input logic [jahd_pkg::HYST_W-1:0] step
  );
    logic [POS_W-1:0] diff;
    diff = (prev > avg) ? prev - avg : avg - prev;
    return (diff > step) ? avg : prev;
  endfunction

  logic [POS_W-1:0]    new_x;
  logic [POS_W-1:0]    new_y;
  logic [CMP_W-1:0]    ax;
  logic [CMP_W-1:0]    ay;
  logic [CMP_W-1:0]    dz;
  logic [CMP_W-1:0]    mid;
  jahd_pkg::dir_t      dir;

  assign new_x = hyst_pick(last_x_r, avg_x_r, hyst_r);
  assign new_y = hyst_pick(last_y_r, avg_y_r, hyst_r);
  assign ax    = CMP_W'(avg_x_r);
  assign ay    = CMP_W'(avg_y_r);
  assign dz    = CMP_W'(dead_r);
  assign mid   = CMP_W'(jahd_pkg::CENTRE_POS);

  // lower bound compared as value + dead zone < centre, so it never goes negative
  always_comb begin
    if (ay > ax && ay > mid + dz) begin
      dir = jahd_pkg::DIR_UP;
    end else if (ax > ay && ay + dz < mid) begin
      dir = jahd_pkg::DIR_DOWN;
    end else if (ax < ay && ax + dz < mid) begin
      dir = jahd_pkg::DIR_LEFT;
    end else if (ax > ay && ax > mid + dz) begin
      dir = jahd_pkg::DIR_RIGHT;
    end else begin
      dir = jahd_pkg::DIR_NEUTRAL;
    end
  end

  // accumulators, counter and reported positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r  <= '0;
      acc_y_r  <= '0;
      count_r  <= '0;
      last_x_r <= jahd_pkg::CENTRE_POS;
      last_y_r <= jahd_pkg::CENTRE_POS;
    end else begin
      if (cmd.cap_map_y) begin
        acc_y_r <= acc_y_r + jahd_pkg::ACC_W'(map_y);
      end
      if (cmd.cap_map_x) begin
        acc_x_r <= acc_x_r + jahd_pkg::ACC_W'(map_x);
        count_r <= count_r + jahd_pkg::CNT_W'(1);
      end
      if (cmd.publish) begin
        acc_x_r  <= '0;
        acc_y_r  <= '0;
        count_r  <= '0;
        last_x_r <= new_x;
        last_y_r <= new_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_avg_x) begin
      avg_x_r <= q_pos;
    end
    if (cmd.cap_avg_y) begin
      avg_y_r <= q_pos;
    end
  end

  // result register
  logic                         out_valid_r;
  logic [POS_W-1:0]             out_x_r;
  logic [POS_W-1:0]             out_y_r;
  logic [jahd_pkg::DIR_W-1:0]   out_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_x_r   <= new_x;
      out_y_r   <= new_y;
      out_dir_r <= dir;
    end
  end

  // window length zero acts as one
  logic [jahd_pkg::WINDOW_W-1:0] win;
  assign win = (window_r == '0) ? jahd_pkg::WINDOW_W'(1) : window_r;

  assign status.div_done = div_done;
  assign status.win_hit  = count_r >= win;
  assign status.out_full = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_x_position = out_x_r;
  assign out_y_position = out_y_r;
  assign out_direction  = out_dir_r;
endmodule

### rtl/core/jahd_ctrl.sv
// sequencing state machine: per-sample mapping divides, window-end averaging and publish
module jahd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jahd_pkg::status_t status,
  output jahd_pkg::cmd_t    cmd
);
  jahd_pkg::state_t state_r;
  jahd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jahd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jahd_pkg::ST_IDLE:     if (in_valid) state_nxt = jahd_pkg::ST_START_Y;
      jahd_pkg::ST_START_Y:  state_nxt = jahd_pkg::ST_WAIT_Y;
      jahd_pkg::ST_WAIT_Y:   if (status.div_done) state_nxt = jahd_pkg::ST_START_X;
      jahd_pkg::ST_START_X:  state_nxt = jahd_pkg::ST_WAIT_X;
      jahd_pkg::ST_WAIT_X:   if (status.div_done) state_nxt = jahd_pkg::ST_CHECK;
      jahd_pkg::ST_CHECK: begin
        state_nxt = status.win_hit ? jahd_pkg::ST_START_AX : jahd_pkg::ST_IDLE;
      end
      jahd_pkg::ST_START_AX: state_nxt = jahd_pkg::ST_WAIT_AX;
      jahd_pkg::ST_WAIT_AX:  if (status.div_done) state_nxt = jahd_pkg::ST_START_AY;
      jahd_pkg::ST_START_AY: state_nxt = jahd_pkg::ST_WAIT_AY;
      jahd_pkg::ST_WAIT_AY:  if (status.div_done) state_nxt = jahd_pkg::ST_RESULT;
      jahd_pkg::ST_RESULT:   if (!status.out_full) state_nxt = jahd_pkg::ST_IDLE;
      default:               state_nxt = jahd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = jahd_pkg::SEL_MAP_Y;
    in_ready = 1'b0;
    case (state_r)
      jahd_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      jahd_pkg::ST_START_Y: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = jahd_pkg::SEL_MAP_Y;
      end
      jahd_pkg::ST_WAIT_Y: begin
        cmd.cap_map_y = status.div_done;
      end
      jahd_pkg::ST_START_X: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = jahd_pkg::SEL_MAP_X;
      end
      jahd_pkg::ST_WAIT_X: begin
        cmd.div_sel   = jahd_pkg::SEL_MAP_X;
        cmd.cap_map_x = status.div_done;
      end
      jahd_pkg::ST_START_AX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = jahd_pkg::SEL_AVG_X;
      end
      jahd_pkg::ST_WAIT_AX: begin
        cmd.div_sel   = jahd_pkg::SEL_AVG_X;
        cmd.cap_avg_x = status.div_done;
      end
      jahd_pkg::ST_START_AY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = jahd_pkg::SEL_AVG_Y;
      end
      jahd_pkg::ST_WAIT_AY: begin
        cmd.div_sel   = jahd_pkg::SEL_AVG_Y;
        cmd.cap_avg_y = status.div_done;
      end
      jahd_pkg::ST_RESULT: begin
        cmd.publish = !status.out_full;
      end
      default: ;
    endcase
  end
endmodule
